FILE: hdl/mau_pkg.sv
// shared types and constants for the modular arithmetic unit
`timescale 1ns / 1ps
package mau_pkg;
    localparam int MOD_BITS = 31;
    localparam int EXP_BITS = 63;
    localparam int WIDE_BITS = 64;
    localparam int CNT_BITS = $clog2(WIDE_BITS + 1);

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_INV    = 3'd5,
        OP_POW    = 3'd6,
        OP_NEG    = 3'd7
    } t_opcode;

    // divider command and response
    typedef struct packed {
        logic                 start;
        logic [WIDE_BITS-1:0] dividend;
        logic [MOD_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [WIDE_BITS-1:0] quot;
        logic [MOD_BITS-1:0]  rem;
    } t_div_rsp;
endpackage

FILE: hdl/mau_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mau_divider
    import mau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [WIDE_BITS-1:0] r_quot, n_quot;
    logic [MOD_BITS:0]    r_rem, n_rem;
    logic [MOD_BITS-1:0]  r_div, n_div;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 r_busy, n_busy, r_done, n_done;
    logic [MOD_BITS+1:0]  trial;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quot[WIDE_BITS-1]} - {2'b00, r_div};
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_div  = i_req.divisor;
            n_cnt  = CNT_BITS'(WIDE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in the next dividend bit, keep the quotient bit
            if (!trial[MOD_BITS+1]) begin
                n_rem = trial[MOD_BITS:0];
            end else begin
                n_rem = {r_rem[MOD_BITS-1:0], r_quot[WIDE_BITS-1]};
            end
            n_quot = {r_quot[WIDE_BITS-2:0], ~trial[MOD_BITS+1]};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[MOD_BITS-1:0];
endmodule

FILE: hdl/mau_sequencer.sv
// operation sequencer driving the shared divider
`timescale 1ns / 1ps
module mau_sequencer
    import mau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0]           i_opcode,
    input  logic [WIDE_BITS-1:0] i_wide_value,
    input  logic [MOD_BITS-1:0]  i_operand_a,
    input  logic [MOD_BITS-1:0]  i_operand_b,
    input  logic [EXP_BITS-1:0]  i_exponent,
    input  logic [MOD_BITS-1:0]  i_mod,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [MOD_BITS-1:0]  o_result,
    output logic                 o_status,
    output t_div_req             o_req,
    input  t_div_rsp             i_rsp
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_RA    = 12'b000000000010, // a mod m
        S_RB    = 12'b000000000100, // b mod m
        S_DISP  = 12'b000000001000,
        S_SIMP  = 12'b000000010000, // single reduction ends op
        S_EUC   = 12'b000000100000, // euclid divide step
        S_EUCF  = 12'b000001000000, // s update mod m
        S_PACC  = 12'b000010000000, // acc*base
        S_PSQ   = 12'b000100000000, // base*base
        S_PNEXT = 12'b001000000000,
        S_DMUL  = 12'b010000000000, // a*inv for div
        S_DONE  = 12'b100000000000
    } t_state;

    t_state r_st, n_st;
    logic [2:0]           r_op, n_op;
    logic [WIDE_BITS-1:0] r_w, n_w;
    logic [MOD_BITS-1:0]  r_a, n_a, r_b, n_b, r_m, n_m;
    logic [EXP_BITS-1:0]  r_e, n_e;
    logic [MOD_BITS-1:0]  r_acc, n_acc;
    // euclid: residues and coefficients held mod m
    logic [MOD_BITS-1:0]  r_r0, n_r0, r_r1, n_r1, r_s0, n_s0, r_s1, n_s1;
    logic [MOD_BITS-1:0]  r_res, n_res;
    logic                 r_stat, n_stat, r_valid, n_valid;
    logic                 r_neg, n_neg;
    t_div_req             req;
    logic [MOD_BITS:0]    diff;
    logic [MOD_BITS-1:0]  rem_fix;

    // negative reduce: m - r when r nonzero
    assign rem_fix = (i_rsp.rem == '0) ? '0 : r_m - i_rsp.rem;
    assign diff    = {1'b0, r_s0} - {1'b0, i_rsp.rem};

    always_comb begin
        n_st = r_st; n_op = r_op; n_w = r_w; n_a = r_a; n_b = r_b; n_m = r_m;
        n_e = r_e; n_acc = r_acc; n_r0 = r_r0; n_r1 = r_r1; n_s0 = r_s0;
        n_s1 = r_s1; n_res = r_res; n_stat = r_stat;
        n_valid = 1'b0; n_neg = r_neg;
        req = '0;
        unique case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_opcode; n_w = i_wide_value; n_e = i_exponent;
                    n_a = i_operand_a; n_b = i_operand_b;
                    n_m = (i_mod == '0) ? MOD_BITS'(1) : i_mod;
                    n_stat = 1'b0; n_res = '0;
                    n_st = S_RA;
                    req.start = 1'b1;
                    req.dividend = WIDE_BITS'(i_operand_a);
                    req.divisor = (i_mod == '0) ? MOD_BITS'(1) : i_mod;
                end
            end
            S_RA: if (i_rsp.done) begin
                n_a = i_rsp.rem;
                n_st = S_RB;
                req.start = 1'b1;
                req.dividend = WIDE_BITS'(r_b);
                req.divisor = r_m;
            end
            S_RB: if (i_rsp.done) begin
                n_b = i_rsp.rem;
                n_st = S_DISP;
            end
            S_DISP: begin
                req.divisor = r_m;
                n_neg = 1'b0;
                unique case (t_opcode'(r_op))
                    OP_REDUCE: begin
                        n_neg = r_w[WIDE_BITS-1];
                        req.start = 1'b1;
                        req.dividend = r_w[WIDE_BITS-1] ? (~r_w + 1'b1) : r_w;
                        n_st = S_SIMP;
                    end
                    OP_ADD: begin
                        req.start = 1'b1;
                        req.dividend = WIDE_BITS'(r_a) + WIDE_BITS'(r_b);
                        n_st = S_SIMP;
                    end
                    OP_SUB: begin
                        req.start = 1'b1;
                        req.dividend = WIDE_BITS'(r_a) + WIDE_BITS'(r_m)
                                     - WIDE_BITS'(r_b);
                        n_st = S_SIMP;
                    end
                    OP_MUL: begin
                        req.start = 1'b1;
                        req.dividend = WIDE_BITS'(r_a) * WIDE_BITS'(r_b);
                        n_st = S_SIMP;
                    end
                    OP_NEG: begin
                        req.start = 1'b1;
                        req.dividend = WIDE_BITS'(r_m) - WIDE_BITS'(r_a);
                        n_st = S_SIMP;
                    end
                    OP_DIV, OP_INV: begin
                        n_r0 = (t_opcode'(r_op) == OP_DIV) ? r_b : r_a;
                        n_r1 = r_m; n_s0 = MOD_BITS'(1); n_s1 = '0;
                        if (n_r0 == '0) begin
                            n_stat = 1'b1; n_res = '0; n_st = S_DONE;
                        end else begin
                            req.start = 1'b1;
                            req.dividend = WIDE_BITS'(n_r0);
                            req.divisor = r_m;
                            n_st = S_EUC;
                        end
                    end
                    OP_POW: begin
                        n_acc = (r_m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                        n_st = S_PNEXT;
                    end
                    default: n_st = S_DONE;
                endcase
            end
            S_SIMP: if (i_rsp.done) begin
                n_res = r_neg ? rem_fix : i_rsp.rem;
                n_st = S_DONE;
            end
            S_EUC: if (i_rsp.done) begin
                // r0 / r1: quotient and remainder
                n_r0 = r_r1; n_r1 = i_rsp.rem;
                // q*s1 reduced mod m
                req.start = 1'b1;
                req.dividend = WIDE_BITS'(i_rsp.quot[MOD_BITS-1:0]) * WIDE_BITS'(r_s1);
                req.divisor = r_m;
                n_st = S_EUCF;
            end
            S_EUCF: if (i_rsp.done) begin
                n_s0 = r_s1;
                n_s1 = diff[MOD_BITS] ? (r_s0 + r_m - i_rsp.rem) : diff[MOD_BITS-1:0];
                if (r_r1 == '0) begin
                    // r0 is the gcd; s in n_s0
                    if (r_r0 != MOD_BITS'(1)) begin
                        n_stat = 1'b1; n_res = '0; n_st = S_DONE;
                    end else if (t_opcode'(r_op) == OP_INV) begin
                        n_res = (r_m == MOD_BITS'(1)) ? '0 : r_s1;
                        n_st = S_DONE;
                    end else begin
                        req.start = 1'b1;
                        req.dividend = WIDE_BITS'(r_a) * WIDE_BITS'(r_s1);
                        req.divisor = r_m;
                        n_st = S_DMUL;
                    end
                end else begin
                    req.start = 1'b1;
                    req.dividend = WIDE_BITS'(r_r0);
                    req.divisor = r_r1;
                    n_st = S_EUC;
                end
            end
            S_DMUL: if (i_rsp.done) begin
                n_res = i_rsp.rem; n_st = S_DONE;
            end
            S_PNEXT: begin
                if (r_e == '0) begin
                    n_res = r_acc; n_st = S_DONE;
                end else if (r_e[0]) begin
                    req.start = 1'b1;
                    req.dividend = WIDE_BITS'(r_acc) * WIDE_BITS'(r_a);
                    req.divisor = r_m;
                    n_st = S_PACC;
                end else begin
                    req.start = 1'b1;
                    req.dividend = WIDE_BITS'(r_a) * WIDE_BITS'(r_a);
                    req.divisor = r_m;
                    n_st = S_PSQ;
                end
            end
            S_PACC: if (i_rsp.done) begin
                n_acc = i_rsp.rem;
                req.start = 1'b1;
                req.dividend = WIDE_BITS'(r_a) * WIDE_BITS'(r_a);
                req.divisor = r_m;
                n_st = S_PSQ;
            end
            S_PSQ: if (i_rsp.done) begin
                n_a = i_rsp.rem;
                n_e = r_e >> 1;
                n_st = S_PNEXT;
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_valid <= n_valid;
        end
        r_op <= n_op; r_w <= n_w; r_a <= n_a; r_b <= n_b; r_m <= n_m;
        r_e <= n_e; r_acc <= n_acc; r_r0 <= n_r0; r_r1 <= n_r1;
        r_s0 <= n_s0; r_s1 <= n_s1; r_res <= n_res;
        r_stat <= n_stat; r_neg <= n_neg;
    end

    assign o_busy   = (r_st != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;
    assign o_status = r_stat;
    assign o_req    = req;
endmodule

FILE: hdl/modular_arithmetic_unit.sv
// Each divide runs 64 shift steps. Reduce, add, sub, mul, negate: reduce a, reduce b, then
// one op divide; div and inverse: the two reductions, two divides per euclid step, one more
// for div; power: the two reductions, a squaring per exponent bit, a multiply per set bit.
// One transaction at a time: busy stays high until the strobe cycle, when the next may start.
// Reset (synchronous, active low) idles the sequencer and sets the modulus to 1.
// The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_opcode,
    input  logic [WIDE_BITS-1:0] i_wide_value,
    input  logic [MOD_BITS-1:0]  i_operand_a,
    input  logic [MOD_BITS-1:0]  i_operand_b,
    input  logic [EXP_BITS-1:0]  i_exponent,
    output logic                 o_valid,
    output logic [MOD_BITS-1:0]  o_result,
    output logic                 o_status
);
    logic [MOD_BITS-1:0] r_mod;
    t_div_req req;
    t_div_rsp rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_BITS'(1);
        end else if (psel && penable && pwrite && paddr == 2'b00) begin
            r_mod <= pwdata[MOD_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'b00) ? 32'(r_mod) : 32'd0;

    mau_sequencer u_seq (
        .i_clk, .i_rst_n,
        .i_start(start && !busy),
        .i_opcode, .i_wide_value, .i_operand_a, .i_operand_b, .i_exponent,
        .i_mod(r_mod),
        .o_busy(busy), .o_valid, .o_result, .o_status,
        .o_req(req), .i_rsp(rsp)
    );

    mau_divider u_div (.i_clk, .i_rst_n, .i_req(req), .o_rsp(rsp));
endmodule
